/* hw/rtl/ihc_pkg.sv */
// Shared types and constants for the IPv4 header check and TTL update block.
`timescale 1ns / 1ps

package ihc_pkg;

    localparam int unsigned ETH_HEADER_BYTES    = 14;
    localparam int unsigned IP_MIN_HEADER_BYTES = 20;
    localparam int unsigned ARP_HEADER_BYTES    = 8;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETHERTYPE_ARP  = 16'h0806;
    localparam logic [15:0] CSUM_ALL_ONES  = 16'hFFFF;
    localparam logic [16:0] CSUM_TTL_STEP  = 17'h00100;

    // Header byte offsets, counted from the start of the IPv4 header.
    localparam int unsigned IP_OFS_VER_IHL = 0;
    localparam int unsigned IP_OFS_TTL     = 8;
    localparam int unsigned IP_OFS_PROTO   = 9;
    localparam int unsigned IP_OFS_CSUM_HI = 10;
    localparam int unsigned IP_OFS_CSUM_LO = 11;
    localparam int unsigned IP_OFS_DST_LO  = 16;
    localparam int unsigned IP_OFS_DST_HI  = 19;

    localparam int unsigned ETH_OFS_TYPE_HI = 12;
    localparam int unsigned ETH_OFS_TYPE_LO = 13;

    typedef enum logic [2:0] {
        ST_IPV4_OK    = 3'd0,
        ST_TTL_ZERO   = 3'd1,
        ST_CSUM_BAD   = 3'd2,
        ST_IPV4_SHORT = 3'd3,
        ST_ARP        = 3'd4,
        ST_ARP_SHORT  = 3'd5,
        ST_FRAME_SHORT = 3'd6,
        ST_OTHER      = 3'd7
    } status_t;

    typedef struct packed {
        status_t     status;
        logic        ttl_expired;
        logic [31:0] dest_address;
        logic [7:0]  protocol_number;
        logic [7:0]  next_ttl;
        logic [15:0] next_checksum;
    } ihc_result_t;

endpackage

/* hw/rtl/ihc_parse.sv */
// Per-frame field capture, header checksum accumulation and verdict logic.
`timescale 1ns / 1ps

module ihc_parse
    import ihc_pkg::*;
#(
    parameter int unsigned COUNT_BITS = 12
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        beat,
    input  logic [7:0]  frame_byte,
    input  logic        last_byte,
    output ihc_result_t result
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] ETH_LEN   = COUNT_BITS'(ETH_HEADER_BYTES);

    logic [COUNT_BITS-1:0] byte_count_reg, byte_count_next;
    logic [15:0]           ethertype_reg, ethertype_next;
    logic [3:0]            ihl_reg, ihl_next;
    logic [20:0]           sum_reg, sum_next;
    logic [7:0]            pending_reg, pending_next;
    logic [7:0]            ttl_reg, ttl_next;
    logic [7:0]            proto_reg, proto_next;
    logic [31:0]           dest_reg, dest_next;
    logic [15:0]           csum_reg, csum_next;

    logic [COUNT_BITS-1:0] hdr_pos;
    logic                  in_ip;
    logic [5:0]            hdr_len;
    logic [6:0]            hdr_min;
    logic [6:0]            ip_need;
    logic                  in_sum;
    logic [16:0]           fold1;
    logic [16:0]           fold2;
    logic [16:0]           csum_inc;

    // Field capture and running sum for the byte now being accepted.
    always_comb
    begin
        ethertype_next = ethertype_reg;
        ihl_next       = ihl_reg;
        sum_next       = sum_reg;
        pending_next   = pending_reg;
        ttl_next       = ttl_reg;
        proto_next     = proto_reg;
        dest_next      = dest_reg;
        csum_next      = csum_reg;

        in_ip   = (byte_count_reg >= ETH_LEN);
        hdr_pos = byte_count_reg - ETH_LEN;

        if (byte_count_reg == COUNT_BITS'(ETH_OFS_TYPE_HI) ||
            byte_count_reg == COUNT_BITS'(ETH_OFS_TYPE_LO))
        begin
            ethertype_next = {ethertype_reg[7:0], frame_byte};
        end

        if (in_ip && hdr_pos == COUNT_BITS'(IP_OFS_VER_IHL))
        begin
            ihl_next = frame_byte[3:0];
        end
        if (in_ip && hdr_pos == COUNT_BITS'(IP_OFS_TTL))
        begin
            ttl_next = frame_byte;
        end
        if (in_ip && hdr_pos == COUNT_BITS'(IP_OFS_PROTO))
        begin
            proto_next = frame_byte;
        end
        if (in_ip && (hdr_pos == COUNT_BITS'(IP_OFS_CSUM_HI) ||
                      hdr_pos == COUNT_BITS'(IP_OFS_CSUM_LO)))
        begin
            csum_next = {csum_reg[7:0], frame_byte};
        end
        if (in_ip && hdr_pos >= COUNT_BITS'(IP_OFS_DST_LO) &&
            hdr_pos <= COUNT_BITS'(IP_OFS_DST_HI))
        begin
            dest_next = {dest_reg[23:0], frame_byte};
        end

        // The IHL byte itself already counts toward the header length.
        hdr_len = {ihl_next, 2'b00};
        in_sum  = in_ip && (hdr_pos < COUNT_BITS'(hdr_len));
        if (in_sum)
        begin
            if (!hdr_pos[0])
            begin
                pending_next = frame_byte;
            end
            else
            begin
                sum_next = sum_reg + 21'({pending_reg, frame_byte});
            end
        end

        byte_count_next = (byte_count_reg == COUNT_MAX) ? byte_count_reg
                                                        : byte_count_reg + 1'b1;
    end

    // Verdict for a frame that ends on this byte.
    always_comb
    begin
        hdr_min  = (hdr_len < 6'(IP_MIN_HEADER_BYTES)) ? 7'(IP_MIN_HEADER_BYTES)
                                                       : {1'b0, hdr_len};
        ip_need  = hdr_min + 7'(ETH_HEADER_BYTES);
        fold1    = {1'b0, sum_next[15:0]} + {12'd0, sum_next[20:16]};
        fold2    = {1'b0, fold1[15:0]} + {16'd0, fold1[16]};
        csum_inc = {1'b0, csum_next} + CSUM_TTL_STEP;

        result = '0;
        result.status = ST_OTHER;
        if (byte_count_next < ETH_LEN)
        begin
            result.status = ST_FRAME_SHORT;
        end
        else if (ethertype_next == ETHERTYPE_IPV4)
        begin
            if (byte_count_next < COUNT_BITS'(ip_need))
            begin
                result.status = ST_IPV4_SHORT;
            end
            else if (fold2[15:0] != CSUM_ALL_ONES)
            begin
                result.status = ST_CSUM_BAD;
            end
            else if (ttl_next == 8'd0)
            begin
                result.status      = ST_TTL_ZERO;
                result.ttl_expired = 1'b1;
            end
            else
            begin
                result.status          = ST_IPV4_OK;
                result.ttl_expired     = (ttl_next <= 8'd1);
                result.dest_address    = dest_next;
                result.protocol_number = proto_next;
                result.next_ttl        = ttl_next - 8'd1;
                result.next_checksum   = csum_inc[15:0] + {15'd0, csum_inc[16]};
            end
        end
        else if (ethertype_next == ETHERTYPE_ARP)
        begin
            result.status = (byte_count_next <
                             COUNT_BITS'(ETH_HEADER_BYTES + ARP_HEADER_BYTES)) ?
                            ST_ARP_SHORT : ST_ARP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            ethertype_reg  <= '0;
            ihl_reg        <= '0;
            sum_reg        <= '0;
            pending_reg    <= '0;
            ttl_reg        <= '0;
            proto_reg      <= '0;
            dest_reg       <= '0;
            csum_reg       <= '0;
        end
        else if (beat)
        begin
            if (last_byte)
            begin
                byte_count_reg <= '0;
                ethertype_reg  <= '0;
                ihl_reg        <= '0;
                sum_reg        <= '0;
                pending_reg    <= '0;
                ttl_reg        <= '0;
                proto_reg      <= '0;
                dest_reg       <= '0;
                csum_reg       <= '0;
            end
            else
            begin
                byte_count_reg <= byte_count_next;
                ethertype_reg  <= ethertype_next;
                ihl_reg        <= ihl_next;
                sum_reg        <= sum_next;
                pending_reg    <= pending_next;
                ttl_reg        <= ttl_next;
                proto_reg      <= proto_next;
                dest_reg       <= dest_next;
                csum_reg       <= csum_next;
            end
        end
    end

    // A frame's last beat leaves no per-frame state behind.
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (beat && last_byte) |=> (byte_count_reg == '0 && sum_reg == '0))
        else $error("per-frame state not cleared after last beat");

    // The saturating counter never wraps back to zero on a non-last beat.
    a_count_no_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (beat && !last_byte) |=> (byte_count_reg != '0))
        else $error("byte counter wrapped inside a frame");

endmodule

/* hw/rtl/ihc_out_buf.sv */
// Two-entry result buffer: output register plus skid register.
`timescale 1ns / 1ps

module ihc_out_buf
    import ihc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  ihc_result_t push_data,
    output logic        has_room,
    output logic        out_valid,
    input  logic        out_ready,
    output ihc_result_t out_data
);

    logic        main_valid_reg, main_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    ihc_result_t main_reg, main_next;
    ihc_result_t skid_reg, skid_next;
    logic        pop;

    assign pop       = main_valid_reg && out_ready;
    assign has_room  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (!main_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_next       = push_data;
                main_valid_next = push;
            end
        end
        else if (push)
        begin
            skid_next       = push_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry held while output register is empty");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !skid_valid_reg)
        else $error("result pushed into a full buffer");

    a_skid_refills_main: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && pop) |=> (main_valid_reg && !skid_valid_reg))
        else $error("skid entry lost on output pop");

endmodule

/* hw/rtl/ipv4_header_check_ttl_update_core.sv */
// Top level of the IPv4 header check and TTL update block.
// Verdicts are registered on the last beat, going to the skid entry while the output is held.
// Throughput: one frame byte per cycle; input ready drops only while two verdicts wait.
// The verdict for a frame is settled in the same cycle as its last byte, from state registers.
// Reset (rst_n, asynchronous, active low) clears all frame state and empties the output buffer.
`timescale 1ns / 1ps

module ipv4_header_check_ttl_update_core
    import ihc_pkg::*;
#(
    parameter int unsigned COUNT_BITS = 12
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  frame_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic        forward_ttl_expired,
    output logic [31:0] dest_address,
    output logic [7:0]  protocol_number,
    output logic [7:0]  next_ttl,
    output logic [15:0] next_checksum
);

    logic        beat;
    logic        has_room;
    ihc_result_t verdict;
    ihc_result_t out_data;

    // Input beats are taken whenever the result buffer can absorb one more
    // verdict. Bytes that are not the last of a frame never produce a result,
    // but gating on buffer room alone keeps ready independent of the payload.
    assign in_ready = has_room;
    assign beat     = in_valid && in_ready;

    // The parser updates its per-frame registers on every beat and presents
    // the verdict that the current beat would close, combinationally.
    ihc_parse #(
        .COUNT_BITS (COUNT_BITS)
    ) u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .beat       (beat),
        .frame_byte (frame_byte),
        .last_byte  (last_byte),
        .result     (verdict)
    );

    // The verdict is registered only for the last beat of a frame. A skid
    // entry behind the output register lets the next frame stream in while a
    // verdict is held by a stalled consumer.
    ihc_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (beat && last_byte),
        .push_data (verdict),
        .has_room  (has_room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign status              = out_data.status;
    assign forward_ttl_expired = out_data.ttl_expired;
    assign dest_address        = out_data.dest_address;
    assign protocol_number     = out_data.protocol_number;
    assign next_ttl            = out_data.next_ttl;
    assign next_checksum       = out_data.next_checksum;

    // A verdict can only be presented after at least one frame end was taken.
    a_out_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid && !(beat && last_byte)) |=> !out_valid)
        else $error("verdict appeared without a frame end");

    // Only the forwarding case carries header fields.
    a_fields_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_IPV4_OK) |-> (dest_address == 32'd0 &&
            next_checksum == 16'd0 && next_ttl == 8'd0))
        else $error("header fields present on a non-forwarding verdict");

endmodule
